>>> sv/brfo_pkg.sv
// Shared types and codes for the byte ring FIFO.
// No dependencies; compile before every other file.
`default_nettype none

package brfo_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] WS_STORED = 2'd0;
    localparam logic [1:0] WS_OVER   = 2'd1;
    localparam logic [1:0] WS_DROP   = 2'd2;

    localparam logic POLICY_OVERWRITE = 1'b0;

    localparam int OpW   = 2;
    localparam int ByteW = 8;
    localparam int LenW  = 7;
    localparam int FillW = 11;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

`default_nettype wire

>>> sv/brfo_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on brfo_pkg.
`default_nettype none

interface brfo_in_if;
    logic                       valid;
    logic                       ready;
    logic [brfo_pkg::OpW-1:0]   op;
    logic [brfo_pkg::ByteW-1:0] data_byte;
    logic                       burst_end;
    logic [brfo_pkg::LenW-1:0]  max_len;

    modport source (output valid, op, data_byte, burst_end, max_len, input ready);
    modport sink   (input valid, op, data_byte, burst_end, max_len, output ready);
endinterface

interface brfo_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [brfo_pkg::ByteW-1:0] read_byte;
    logic [1:0]                 write_status;
    logic                       last;
    logic                       notify;
    logic [brfo_pkg::FillW-1:0] fill_level;

    modport source (output valid, kind, read_byte, write_status, last, notify, fill_level,
                    input ready);
    modport sink   (input valid, kind, read_byte, write_status, last, notify, fill_level,
                    output ready);
endinterface

`default_nettype wire

>>> sv/brfo_ram.sv
// Byte store: one write port, one read port, registered read data.
// Depends on brfo_pkg.
`default_nettype none

module brfo_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                            i_clk,
    input  wire brfo_pkg::t_ram_ctl        i_ctl,
    input  wire [AW-1:0]                   i_waddr,
    input  wire [brfo_pkg::ByteW-1:0]      i_wdata,
    input  wire [AW-1:0]                   i_raddr,
    output logic [brfo_pkg::ByteW-1:0]     o_rdata
);

    logic [brfo_pkg::ByteW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/brfo_ctrl.sv
// Pointer, fill and sequencing logic plus the result register.
// Depends on brfo_pkg and brfo_if; drives the brfo_ram ports.
`default_nettype none

module brfo_ctrl #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64,
    parameter int AW       = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_policy,
    brfo_in_if.sink                      i_in,
    brfo_out_if.source                   o_out,
    output brfo_pkg::t_ram_ctl           o_ram_ctl,
    output logic [AW-1:0]                o_waddr,
    output logic [brfo_pkg::ByteW-1:0]   o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  wire [brfo_pkg::ByteW-1:0]    i_rdata
);

    localparam int FW   = $clog2(DEPTH + 1);
    localparam int CW   = $clog2(MAX_READ + 1);
    localparam int CMPW = (FW > brfo_pkg::LenW) ? FW : brfo_pkg::LenW;
    localparam int FLW  = (FW > brfo_pkg::FillW) ? FW : brfo_pkg::FillW;

    brfo_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_dropped, n_dropped;
    logic [CW-1:0] r_left, n_left;

    logic                       r_ov, n_ov;
    logic [1:0]                 r_kind, n_kind;
    logic [brfo_pkg::ByteW-1:0] r_rbyte, n_rbyte;
    logic [1:0]                 r_status, n_status;
    logic                       r_last, n_last;
    logic                       r_notify, n_notify;
    logic [FW-1:0]              r_flv, n_flv;

    logic                          slot_free, in_ready, acc, load, issue_next, full;
    logic [AW-1:0]                 wr_adv, rd_adv;
    logic [brfo_pkg::LenW-1:0]     len_cap;
    logic [CMPW-1:0]               len_x, fill_x, run_x;
    logic [CW-1:0]                 run;
    logic                          drop_now, dflag;
    logic [FLW-1:0]                flv_x;

    assign slot_free = !r_ov || o_out.ready;
    assign full      = (r_fill == FW'(DEPTH));
    assign wr_adv    = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_adv    = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    assign len_cap = (i_in.max_len > brfo_pkg::LenW'(MAX_READ)) ?
                     brfo_pkg::LenW'(MAX_READ) : i_in.max_len;
    assign len_x   = CMPW'(len_cap);
    assign fill_x  = CMPW'(r_fill);
    assign run_x   = (len_x < fill_x) ? len_x : fill_x;
    assign run     = run_x[CW-1:0];

    assign drop_now = full && (i_policy != brfo_pkg::POLICY_OVERWRITE);
    assign dflag    = r_dropped || drop_now;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brfo_pkg::ST_IDLE: begin
                if (acc && i_in.op == brfo_pkg::OP_READ && run != '0) begin
                    n_state = brfo_pkg::ST_READ;
                end
            end
            brfo_pkg::ST_READ: begin
                if (load && r_left == '0) begin
                    n_state = brfo_pkg::ST_IDLE;
                end
            end
            default: n_state = brfo_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready   = 1'b0;
        load       = 1'b0;
        issue_next = 1'b0;
        case (r_state)
            brfo_pkg::ST_IDLE: begin
                in_ready = slot_free;
            end
            brfo_pkg::ST_READ: begin
                load       = slot_free;
                issue_next = slot_free && (r_left != '0);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign acc         = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;

    assign o_ram_ctl.we = acc && (i_in.op == brfo_pkg::OP_WRITE) && !drop_now;
    assign o_ram_ctl.re = (acc && (i_in.op == brfo_pkg::OP_READ) && (run != '0)) || issue_next;
    assign o_waddr      = r_wr_ptr;
    assign o_wdata      = i_in.data_byte;
    assign o_raddr      = r_rd_ptr;

    // datapath
    always_comb begin
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_fill    = r_fill;
        n_dropped = r_dropped;
        n_left    = r_left;
        n_ov      = r_ov && !o_out.ready;
        n_kind    = r_kind;
        n_rbyte   = r_rbyte;
        n_status  = r_status;
        n_last    = r_last;
        n_notify  = r_notify;
        n_flv     = r_flv;
        if (acc) begin
            case (i_in.op)
                brfo_pkg::OP_WRITE: begin
                    n_ov     = 1'b1;
                    n_kind   = brfo_pkg::KIND_WRITE;
                    n_rbyte  = '0;
                    n_last   = 1'b1;
                    n_notify = i_in.burst_end && !dflag;
                    n_dropped = i_in.burst_end ? 1'b0 : dflag;
                    if (!full) begin
                        n_wr_ptr = wr_adv;
                        n_fill   = r_fill + 1'b1;
                        n_status = brfo_pkg::WS_STORED;
                    end else if (!drop_now) begin
                        n_wr_ptr = wr_adv;
                        n_rd_ptr = rd_adv;
                        n_status = brfo_pkg::WS_OVER;
                    end else begin
                        n_status = brfo_pkg::WS_DROP;
                    end
                    n_flv = (!full) ? r_fill + 1'b1 : r_fill;
                end
                brfo_pkg::OP_READ: begin
                    if (run == '0) begin
                        n_ov     = 1'b1;
                        n_kind   = brfo_pkg::KIND_EMPTY;
                        n_rbyte  = '0;
                        n_status = brfo_pkg::WS_STORED;
                        n_last   = 1'b1;
                        n_notify = 1'b0;
                        n_flv    = r_fill;
                    end else begin
                        n_rd_ptr = rd_adv;
                        n_fill   = r_fill - 1'b1;
                        n_left   = run - 1'b1;
                    end
                end
                brfo_pkg::OP_CLEAR: begin
                    n_wr_ptr  = '0;
                    n_rd_ptr  = '0;
                    n_fill    = '0;
                    n_dropped = 1'b0;
                    n_ov      = 1'b1;
                    n_kind    = brfo_pkg::KIND_CLEAR;
                    n_rbyte   = '0;
                    n_status  = brfo_pkg::WS_STORED;
                    n_last    = 1'b1;
                    n_notify  = 1'b0;
                    n_flv     = '0;
                end
                default: begin
                    n_ov = r_ov && !o_out.ready;
                end
            endcase
        end
        if (load) begin
            // byte issued on an earlier read strobe; r_fill already counts it out
            n_ov     = 1'b1;
            n_kind   = brfo_pkg::KIND_BYTE;
            n_rbyte  = i_rdata;
            n_status = brfo_pkg::WS_STORED;
            n_last   = (r_left == '0);
            n_notify = 1'b0;
            n_flv    = r_fill;
        end
        if (issue_next) begin
            n_rd_ptr = rd_adv;
            n_fill   = r_fill - 1'b1;
            n_left   = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= brfo_pkg::ST_IDLE;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_fill    <= '0;
            r_dropped <= 1'b0;
            r_left    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
            r_left    <= n_left;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_rbyte  <= n_rbyte;
        r_status <= n_status;
        r_last   <= n_last;
        r_notify <= n_notify;
        r_flv    <= n_flv;
    end

    assign flv_x              = FLW'(r_flv);
    assign o_out.valid        = r_ov;
    assign o_out.kind         = r_kind;
    assign o_out.read_byte    = r_rbyte;
    assign o_out.write_status = r_status;
    assign o_out.last         = r_last;
    assign o_out.notify       = r_notify;
    assign o_out.fill_level   = flv_x[brfo_pkg::FillW-1:0];

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count above depth");

    a_no_empty_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brfo_pkg::ST_READ && r_left != '0) |-> r_fill != '0)
        else $error("read run outlasts held bytes");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_ctl.we && o_ram_ctl.re))
        else $error("store written and read in one cycle");

    a_run_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brfo_pkg::ST_READ && !slot_free) |=> $stable(r_rd_ptr))
        else $error("read pointer moved while result stalled");

endmodule

`default_nettype wire

>>> sv/byte_ring_fifo_overwrite_policy.sv
// Top level of the byte ring FIFO: policy register, control and byte store.
// Depends on brfo_pkg, brfo_if, brfo_ram and brfo_ctrl.
//
//   channel   dir   handshake     word
//   i_in      in    valid/ready   op, data_byte, burst_end, max_len
//   o_out     out   valid/ready   kind, read_byte, write_status, last, notify, fill_level
//   cfg       in    i_cfg_we      i_cfg_wdata -> r_policy
//
// A read returning n bytes is served through the single store read port, whose read data is registered.
// Reset is synchronous; pointers, fill and policy clear, store contents stay undefined.
// A stalled result holds the block; no new word is taken until it is free.
`default_nettype none

module byte_ring_fifo_overwrite_policy #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    brfo_in_if.sink     i_in,
    brfo_out_if.source  o_out
);

    localparam int AW = $clog2(DEPTH);

    logic                        r_policy;
    brfo_pkg::t_ram_ctl          ram_ctl;
    logic [AW-1:0]               waddr, raddr;
    logic [brfo_pkg::ByteW-1:0]  wdata, rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= brfo_pkg::POLICY_OVERWRITE;
        end else if (i_cfg_we) begin
            r_policy <= i_cfg_wdata;
        end
    end

    brfo_ctrl #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ),
        .AW       (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_policy  (r_policy),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_ram_ctl (ram_ctl),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata)
    );

    brfo_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for byte_ring_fifo_overwrite_policy: a table of directed words, then
// random writes, reads and clears under both full policies.
// Depends on brfo_pkg, brfo_if and the RTL of the block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;
    localparam logic [brfo_pkg::OpW-1:0] OP_IDLE = 2'd3;
    localparam logic POLICY_DISCARD = 1'b1;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [brfo_pkg::ByteW-1:0] rbyte;
        logic [1:0]                 status;
        logic                       last;
        logic                       notify;
        logic [brfo_pkg::FillW-1:0] fill;
    } t_result;

    typedef struct packed {
        logic [brfo_pkg::OpW-1:0]   op;
        logic [brfo_pkg::ByteW-1:0] data;
        logic                       bend;
        logic [brfo_pkg::LenW-1:0]  len;
        logic                       typed;
        t_result                    want;
    } t_row;

    localparam int ROWS = 19;
    localparam t_row SCRIPT [ROWS] = '{
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd1,   1'b1,
          '{brfo_pkg::KIND_EMPTY, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd0}},
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd0,   1'b1,
          '{brfo_pkg::KIND_EMPTY, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd0}},
        '{OP_IDLE,            8'h00, 1'b0, 7'd0,   1'b0, '0},
        '{brfo_pkg::OP_WRITE, 8'h00, 1'b0, 7'd0,   1'b1,
          '{brfo_pkg::KIND_WRITE, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd1}},
        '{brfo_pkg::OP_WRITE, 8'hFF, 1'b1, 7'd127, 1'b1,
          '{brfo_pkg::KIND_WRITE, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b1, 11'd2}},
        '{brfo_pkg::OP_WRITE, 8'hA5, 1'b1, 7'd0,   1'b0, '0},
        '{brfo_pkg::OP_READ,  8'hFF, 1'b1, 7'd127, 1'b0, '0},
        '{brfo_pkg::OP_WRITE, 8'h5A, 1'b0, 7'd64,  1'b0, '0},
        '{brfo_pkg::OP_WRITE, 8'h3C, 1'b1, 7'd1,   1'b0, '0},
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd1,   1'b0, '0},
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd64,  1'b0, '0},
        '{brfo_pkg::OP_CLEAR, 8'h00, 1'b0, 7'd0,   1'b1,
          '{brfo_pkg::KIND_CLEAR, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd0}},
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd64,  1'b1,
          '{brfo_pkg::KIND_EMPTY, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd0}},
        '{brfo_pkg::OP_WRITE, 8'h81, 1'b0, 7'd0,   1'b0, '0},
        '{brfo_pkg::OP_WRITE, 8'h7E, 1'b1, 7'd0,   1'b0, '0},
        '{OP_IDLE,            8'hFF, 1'b1, 7'd127, 1'b0, '0},
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd2,   1'b0, '0},
        '{brfo_pkg::OP_CLEAR, 8'hFF, 1'b1, 7'd127, 1'b1,
          '{brfo_pkg::KIND_CLEAR, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd0}},
        '{brfo_pkg::OP_READ,  8'h00, 1'b0, 7'd65,  1'b1,
          '{brfo_pkg::KIND_EMPTY, 8'h00, brfo_pkg::WS_STORED, 1'b1, 1'b0, 11'd0}}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    brfo_in_if  in_if ();
    brfo_out_if out_if ();

    byte_ring_fifo_overwrite_policy #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // predicted ring state
    logic [brfo_pkg::ByteW-1:0] ring_mem [DEPTH];
    logic [9:0]                 wr_idx;
    logic [9:0]                 rd_idx;
    int                         held;
    logic                       burst_lost;
    logic                       policy;

    t_result batch [$];
    t_result due_words [$];
    int      errors;
    bit      calm;

    function automatic void apply_word(logic [brfo_pkg::OpW-1:0] op,
                                       logic [brfo_pkg::ByteW-1:0] data,
                                       logic bend, logic [brfo_pkg::LenW-1:0] len);
        int      n;
        t_result r;
        batch.delete();
        r      = '0;
        r.last = 1'b1;
        case (op)
            brfo_pkg::OP_WRITE: begin
                r.kind = brfo_pkg::KIND_WRITE;
                if (held < DEPTH) begin
                    ring_mem[wr_idx] = data;
                    wr_idx           = wr_idx + 1'b1;
                    held++;
                    r.status = brfo_pkg::WS_STORED;
                end else if (policy == brfo_pkg::POLICY_OVERWRITE) begin
                    rd_idx           = rd_idx + 1'b1;
                    ring_mem[wr_idx] = data;
                    wr_idx           = wr_idx + 1'b1;
                    r.status         = brfo_pkg::WS_OVER;
                end else begin
                    burst_lost = 1'b1;
                    r.status   = brfo_pkg::WS_DROP;
                end
                r.notify = bend && !burst_lost;
                if (bend) burst_lost = 1'b0;
                r.fill = brfo_pkg::FillW'(held);
                batch.push_back(r);
            end
            brfo_pkg::OP_READ: begin
                n = (len > MAX_READ) ? MAX_READ : int'(len);
                if (n > held) n = held;
                if (n == 0) begin
                    r.kind = brfo_pkg::KIND_EMPTY;
                    r.fill = brfo_pkg::FillW'(held);
                    batch.push_back(r);
                end
                for (int k = 0; k < n; k++) begin
                    r.kind  = brfo_pkg::KIND_BYTE;
                    r.rbyte = ring_mem[rd_idx];
                    rd_idx  = rd_idx + 1'b1;
                    held--;
                    r.last  = (k == n - 1);
                    r.fill  = brfo_pkg::FillW'(held);
                    batch.push_back(r);
                end
            end
            brfo_pkg::OP_CLEAR: begin
                wr_idx     = '0;
                rd_idx     = '0;
                held       = 0;
                burst_lost = 1'b0;
                r.kind     = brfo_pkg::KIND_CLEAR;
                batch.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(logic [brfo_pkg::OpW-1:0] op, logic [brfo_pkg::ByteW-1:0] data,
                             logic bend, logic [brfo_pkg::LenW-1:0] len, logic typed,
                             t_result want);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.data_byte <= data;
        in_if.burst_end <= bend;
        in_if.max_len   <= len;
        do @(posedge i_clk); while (!in_if.ready);
        apply_word(op, data, bend, len);
        if (typed) due_words.push_back(want);
        else foreach (batch[k]) due_words.push_back(batch[k]);
    endtask

    task automatic set_policy(logic value);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        policy = value;
    endtask

    task automatic mixed_traffic(int quota);
        int sent;
        int pick;
        int blen;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                blen = $urandom_range(1, 8);
                for (int k = 0; k < blen; k++)
                    send_word(brfo_pkg::OP_WRITE, 8'($urandom_range(0, 255)), k == blen - 1,
                              7'($urandom_range(0, 127)), 1'b0, '0);
                sent += blen;
            end else if (pick < 85) begin
                send_word(brfo_pkg::OP_READ, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)),
                          ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 8))
                                                     : 7'($urandom_range(0, 127)),
                          1'b0, '0);
                sent++;
            end else if (pick < 90) begin
                send_word(brfo_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), 1'b0, '0);
                sent++;
            end else if (pick < 95) begin
                send_word(brfo_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), 1'b0, '0);
                sent++;
            end else begin
                send_word(OP_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          7'($urandom_range(0, 127)), 1'b0, '0);
            end
        end
    endtask

    task automatic note(string field, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
        end
    endtask

    task automatic check_word();
        t_result want;
        if (due_words.size() == 0) begin
            errors++;
            $display("%0t: word with none expected, expected none, actual kind %0d fill %0d",
                     $realtime, out_if.kind, out_if.fill_level);
        end else begin
            want = due_words.pop_front();
            note("kind", want.kind, out_if.kind);
            note("read_byte", want.rbyte, out_if.read_byte);
            note("write_status", want.status, out_if.write_status);
            note("last", want.last, out_if.last);
            note("notify", want.notify, out_if.notify);
            note("fill_level", want.fill, out_if.fill_level);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("testbench: errors");
        $finish;
    end

    // result side: random stall bursts plus one long hold-off
    initial begin
        int  stall_left;
        int  got;
        bit  held_off;
        stall_left   = 0;
        got          = 0;
        held_off     = 1'b0;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (out_if.valid && out_if.ready) begin
                check_word();
                got++;
            end
            if (!held_off && got >= 40) begin
                held_off   = 1'b1;
                stall_left = 60;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            out_if.ready <= (stall_left == 0);
            @(posedge i_clk);
        end
    end

    initial begin
        errors          = 0;
        calm            = 1'b0;
        wr_idx          = '0;
        rd_idx          = '0;
        held            = 0;
        burst_lost      = 1'b0;
        policy          = brfo_pkg::POLICY_OVERWRITE;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        in_if.valid     = 1'b0;
        in_if.op        = brfo_pkg::OP_WRITE;
        in_if.data_byte = '0;
        in_if.burst_end = 1'b0;
        in_if.max_len   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[i])
            send_word(SCRIPT[i].op, SCRIPT[i].data, SCRIPT[i].bend, SCRIPT[i].len,
                      SCRIPT[i].typed, SCRIPT[i].want);

        set_policy(POLICY_DISCARD);
        mixed_traffic(30);

        set_policy(brfo_pkg::POLICY_OVERWRITE);
        mixed_traffic(30);

        // tail of the run without idling on either side
        set_policy(POLICY_DISCARD);
        calm = 1'b1;
        mixed_traffic(20);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/brfo_pkg.sv
sv/brfo_if.sv
sv/brfo_ram.sv
sv/brfo_ctrl.sv
sv/byte_ring_fifo_overwrite_policy.sv
tb/sv/testbench.sv
